>>> design/dgcc_pkg.sv
`default_nettype none
package dgcc_pkg;
    localparam int GateCountDef = 24;
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_INNER  = 2'd1;
    localparam logic [1:0] PH_OUTER  = 2'd2;
    localparam logic [1:0] PH_PAIRED = 2'd3;
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_ENTRY  = 2'd1;
    localparam logic [1:0] EV_EXIT   = 2'd2;
    localparam logic [1:0] EV_GLITCH = 2'd3;
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_WINDOW   = 2'd1;
    localparam logic [1:0] REG_STUCK    = 2'd2;

    typedef struct packed {
        logic [4:0]  gate;
        logic        inner_raw;
        logic        outer_raw;
        logic [31:0] now_ms;
    } t_sample;

    typedef struct packed {
        logic [1:0]  phase;
        logic        inner_level;
        logic        outer_level;
        logic [31:0] inner_seen;
        logic [31:0] outer_seen;
        logic [31:0] pair_start;
        logic [31:0] inner_start;
        logic [31:0] outer_start;
    } t_gate_state;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [31:0] entry_total;
        logic [31:0] exit_total;
        logic [15:0] glitch_total;
        logic        sensor_fault;
        logic        count_overflow;
    } t_result;
endpackage
`default_nettype wire

>>> design/dgcc_front.sv
`default_nettype none
// Accept samples into a two-entry queue.
module dgcc_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  dgcc_pkg::t_sample     i_sample,
    output logic                  o_valid,
    input  wire                   i_ready,
    output dgcc_pkg::t_sample     o_sample
);
    dgcc_pkg::t_sample r_q [2];
    logic              r_rd, r_wr;
    logic [1:0]        r_cnt;
    logic              w_push, w_pop;

    assign o_ready  = (r_cnt != 2'd2);
    assign o_valid  = (r_cnt != 2'd0);
    assign o_sample = r_q[r_rd];
    assign w_push   = i_valid && o_ready;
    assign w_pop    = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= i_sample;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

>>> design/dgcc_back.sv
`default_nettype none
// Read gate state, update, write back; no new sample is taken until write-back.
module dgcc_back #(
    parameter int GATE_COUNT = dgcc_pkg::GateCountDef
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  dgcc_pkg::t_sample     i_sample,
    input  wire  [7:0]            i_debounce,
    input  wire  [15:0]           i_window,
    input  wire  [19:0]           i_stuck,
    output logic                  o_valid,
    input  wire                   i_ready,
    output dgcc_pkg::t_result     o_result
);
    localparam int GW = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1;

    dgcc_pkg::t_gate_state r_mem [GATE_COUNT];
    logic [GATE_COUNT-1:0] r_init;
    dgcc_pkg::t_gate_state r_rdat, w_st, w_nx;
    dgcc_pkg::t_sample     r_smp;
    logic                  r_busy, r_inr;
    logic [31:0]           r_ent, r_ext;
    logic [15:0]           r_gl;
    logic                  r_flt, r_ovf;
    logic                  r_ovalid;
    dgcc_pkg::t_result     r_res;
    logic                  w_inr;
    logic [GW-1:0]         w_idx, r_idx;
    logic                  w_fin;
    logic [1:0]            w_ev;
    logic [31:0]           w_ent, w_ext;
    logic [15:0]           w_gl;
    logic                  w_flt, w_ovf, w_bi, w_bo, w_to;

    assign w_inr   = ({27'd0, i_sample.gate} < 32'(GATE_COUNT));
    assign w_idx   = i_sample.gate[GW-1:0];
    assign o_ready = !r_busy;
    assign w_fin   = r_busy && (!r_ovalid || i_ready);
    assign o_valid = r_ovalid;
    assign o_result = r_res;
    assign w_st    = r_init[r_idx] ? r_rdat : '0;

    always_comb begin
        logic [31:0] now;
        now   = r_smp.now_ms;
        w_nx  = w_st;
        w_ev  = dgcc_pkg::EV_NONE;
        w_ent = r_ent;
        w_ext = r_ext;
        w_gl  = r_gl;
        w_flt = r_flt;
        if (r_smp.inner_raw != w_st.inner_level) begin
            if ((now - w_st.inner_seen) >= {24'd0, i_debounce}) begin
                w_nx.inner_level = r_smp.inner_raw;
                w_nx.inner_seen  = now;
                if (r_smp.inner_raw) w_nx.inner_start = now;
            end
        end else begin
            w_nx.inner_seen = now;
        end
        if (r_smp.outer_raw != w_st.outer_level) begin
            if ((now - w_st.outer_seen) >= {24'd0, i_debounce}) begin
                w_nx.outer_level = r_smp.outer_raw;
                w_nx.outer_seen  = now;
                if (r_smp.outer_raw) w_nx.outer_start = now;
            end
        end else begin
            w_nx.outer_seen = now;
        end
        w_bi = w_nx.inner_level;
        w_bo = w_nx.outer_level;
        if (w_bi && (now - w_nx.inner_start) > {12'd0, i_stuck}) w_flt = 1'b1;
        if (w_bo && (now - w_nx.outer_start) > {12'd0, i_stuck}) w_flt = 1'b1;
        w_to = (now - w_st.pair_start) > {16'd0, i_window};
        unique case (w_st.phase)
            dgcc_pkg::PH_IDLE: begin
                if (w_bi && !w_bo) begin
                    w_nx.phase = dgcc_pkg::PH_INNER;
                    w_nx.pair_start = now;
                end else if (w_bo && !w_bi) begin
                    w_nx.phase = dgcc_pkg::PH_OUTER;
                    w_nx.pair_start = now;
                end else if (w_bi && w_bo) begin
                    w_nx.phase = dgcc_pkg::PH_PAIRED;
                    w_gl = r_gl + 16'd1;
                    w_ev = dgcc_pkg::EV_GLITCH;
                end
            end
            dgcc_pkg::PH_INNER: begin
                if (w_to) begin
                    if (!w_bi && !w_bo) w_nx.phase = dgcc_pkg::PH_IDLE;
                end else if (w_bo) begin
                    w_ext = r_ext + 32'd1;
                    w_nx.phase = dgcc_pkg::PH_PAIRED;
                    w_ev = dgcc_pkg::EV_EXIT;
                end else if (!w_bi) begin
                    w_nx.phase = dgcc_pkg::PH_IDLE;
                    w_gl = r_gl + 16'd1;
                    w_ev = dgcc_pkg::EV_GLITCH;
                end
            end
            dgcc_pkg::PH_OUTER: begin
                if (w_to) begin
                    if (!w_bi && !w_bo) w_nx.phase = dgcc_pkg::PH_IDLE;
                end else if (w_bi) begin
                    w_ent = r_ent + 32'd1;
                    w_nx.phase = dgcc_pkg::PH_PAIRED;
                    w_ev = dgcc_pkg::EV_ENTRY;
                end else if (!w_bo) begin
                    w_nx.phase = dgcc_pkg::PH_IDLE;
                    w_gl = r_gl + 16'd1;
                    w_ev = dgcc_pkg::EV_GLITCH;
                end
            end
            default: begin
                if (!w_bi && !w_bo) w_nx.phase = dgcc_pkg::PH_IDLE;
            end
        endcase
        w_ovf = r_ovf || (&w_ent) || (&w_ext);
        if (!r_inr) begin
            w_ev  = dgcc_pkg::EV_NONE;
            w_ent = r_ent;
            w_ext = r_ext;
            w_gl  = r_gl;
            w_flt = r_flt;
            w_ovf = r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rdat <= r_mem[w_idx];
            r_smp  <= i_sample;
            r_idx  <= w_idx;
        end
        if (w_fin && r_inr) begin
            r_mem[r_idx] <= w_nx;
        end
        if (w_fin) begin
            r_res.event_res      <= w_ev;
            r_res.entry_total    <= w_ent;
            r_res.exit_total     <= w_ext;
            r_res.glitch_total   <= w_gl;
            r_res.sensor_fault   <= w_flt;
            r_res.count_overflow <= w_ovf;
        end
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_inr    <= 1'b0;
            r_ovalid <= 1'b0;
            r_init   <= '0;
            r_ent    <= '0;
            r_ext    <= '0;
            r_gl     <= '0;
            r_flt    <= 1'b0;
            r_ovf    <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_busy <= 1'b1;
                r_inr  <= w_inr;
            end else if (w_fin) begin
                r_busy <= 1'b0;
            end
            if (w_fin) begin
                r_ovalid <= 1'b1;
                r_ent <= w_ent;
                r_ext <= w_ext;
                r_gl  <= w_gl;
                r_flt <= w_flt;
                r_ovf <= w_ovf;
                if (r_inr) r_init[r_idx] <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

>>> design/directional_gate_crossing_counter_unit.sv
`default_nettype none
// Channel   Dir  Handshake              Payload
// s_axis    in   s_axis_tvalid/tready   gate, inner_raw, outer_raw, now_ms
// m_axis    out  m_axis_tvalid/tready   event_res, totals, flags
// cfg       in   i_cfg_valid/o_cfg_ready index, data
// In the back end a sample first has its gate state read, then is updated
// and written back; no new sample is taken until that write-back is done.
// A two-entry queue decouples input from the back end; the result register
// lets the next sample's gate state be read while a result waits.
// Reset is synchronous; gate state reads as reset until a gate is written.
module directional_gate_crossing_counter_unit #(
    parameter int GATE_COUNT = dgcc_pkg::GateCountDef
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // [4:0] gate, [5] inner_raw, [6] outer_raw, [38:7] now_ms, zero pad
    input  wire  [39:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // [1:0] event_res, [33:2] entry total, [65:34] exit total,
    // [81:66] glitch_total, [82] sensor_fault, [83] count_overflow, pad
    output logic [87:0]  m_axis_tdata,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [1:0]   i_cfg_index,
    input  wire  [19:0]  i_cfg_data
);
    dgcc_pkg::t_sample w_in, w_q;
    dgcc_pkg::t_result w_res;
    logic              w_qv, w_qr;
    logic [7:0]        r_deb;
    logic [15:0]       r_win;
    logic [19:0]       r_stk;

    assign w_in.gate      = s_axis_tdata[4:0];
    assign w_in.inner_raw = s_axis_tdata[5];
    assign w_in.outer_raw = s_axis_tdata[6];
    assign w_in.now_ms    = s_axis_tdata[38:7];
    assign o_cfg_ready    = 1'b1;
    assign m_axis_tdata   = {4'd0, w_res.count_overflow, w_res.sensor_fault,
                             w_res.glitch_total, w_res.exit_total,
                             w_res.entry_total, w_res.event_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb <= 8'd3;
            r_win <= 16'd2000;
            r_stk <= 20'd30000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dgcc_pkg::REG_DEBOUNCE: r_deb <= i_cfg_data[7:0];
                dgcc_pkg::REG_WINDOW:   r_win <= i_cfg_data[15:0];
                dgcc_pkg::REG_STUCK:    r_stk <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dgcc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_sample(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_sample(w_q)
    );

    dgcc_back #(.GATE_COUNT(GATE_COUNT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_sample(w_q),
        .i_debounce(r_deb), .i_window(r_win), .i_stuck(r_stk),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_result(w_res)
    );
endmodule
`default_nettype wire
